// File: design/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int WORD_W        = 32;
    localparam int ACT_W         = 3;
    localparam int CNT_W         = 11;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CNT_W-1:0]         CAP_RESET  = 11'd1024;
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    // Register index is paddr / 4.
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_REAR  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_NOP        = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

endpackage

// File: design/bdq_req_if.sv
interface bdq_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [bdq_pkg::ACT_W-1:0]                action;
    logic signed [bdq_pkg::WORD_W-1:0]        value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// File: design/bdq_rsp_if.sv
interface bdq_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     ok;
    logic signed [bdq_pkg::WORD_W-1:0]        front_value;
    logic signed [bdq_pkg::WORD_W-1:0]        rear_value;
    logic                                     is_empty;
    logic                                     is_full;
    logic [bdq_pkg::CNT_W-1:0]                entry_count;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, output entry_count, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, input entry_count, output ready);
endinterface

// File: design/bounded_double_ended_queue.sv
// Bounded deque of signed 32-bit words held in a DEPTH-entry ring buffer memory.
// Each request transaction (push front, push rear, pop front, pop rear, no change)
// returns one response transaction with the outcome, front and rear words (-1 when
// empty), empty/full flags and the entry count. One transaction is in flight at a
// time and passes through accept and memory write, registered two-port memory read
// of the new front and rear slots, then load of the response register; the next
// request is taken while that response waits. Capacity (APB offset 0, reset 1024,
// 0 acts as 1, above DEPTH acts as DEPTH) empties the deque when written. Reset and
// capacity writes clear only the pointers, so no memory sweep follows reset.
module bounded_double_ended_queue #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bdq_pkg::APB_AW-1:0]  paddr,
    input  logic [bdq_pkg::APB_DW-1:0]  pwdata,
    output logic [bdq_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    bdq_req_if.sink                     req,
    bdq_rsp_if.source                   rsp
);
    import bdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  cap_reg;
    logic [AW-1:0]     front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ok_reg, ok_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_ok_reg;
    logic signed [WORD_W-1:0]  out_front_reg, out_rear_reg;
    logic                      out_empty_reg, out_full_reg;
    logic [CNT_W-1:0]          out_count_reg;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_front_reg, rd_rear_reg;

    logic              cfg_wr;
    logic              accept;
    logic              rd_en;
    logic              load_out;
    logic [CNT_W-1:0]  lim;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     front_inc, front_dec;
    logic [AW-1:0]     push_rear_addr, rear_addr;
    logic [SW-1:0]     sum_push, sum_rear;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            lim = CNT_W'(DEPTH);
        end
        else
        begin
            lim = cap_reg;
        end
    end

    // Ring pointer arithmetic
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;

    assign sum_push = SW'(front_reg) + SW'(count_reg);
    assign sum_rear = SW'(front_reg) + SW'(count_reg) - SW'(1);
    assign push_rear_addr = (sum_push >= SW'(DEPTH)) ? AW'(sum_push - SW'(DEPTH))
                                                     : AW'(sum_push);
    assign rear_addr = (sum_rear >= SW'(DEPTH)) ? AW'(sum_rear - SW'(DEPTH))
                                                : AW'(sum_rear);

    assign accept = req.valid && req.ready;

    // Request decode
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        wr_en      = 1'b0;
        wr_addr    = push_rear_addr;
        if (cfg_wr)
        begin
            front_next = '0;
            count_next = '0;
        end
        else if (accept)
        begin
            ok_next = 1'b1;
            unique case (req.action)
                ACT_PUSH_FRONT:
                begin
                    if (count_reg >= lim)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                    end
                end
                ACT_PUSH_REAR:
                begin
                    if (count_reg >= lim)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        wr_en      = 1'b1;
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                ACT_POP_REAR:
                begin
                    if (count_reg == '0)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    ok_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            ok_reg    <= 1'b1;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

    // Entry memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_front_reg <= mem[front_reg];
            rd_rear_reg  <= mem[rear_addr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        rd_en     = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_LOAD:
            begin
                load_out = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Response register
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ok_reg    <= ok_reg;
            out_front_reg <= (count_reg == '0) ? EMPTY_WORD : signed'(rd_front_reg);
            out_rear_reg  <= (count_reg == '0) ? EMPTY_WORD : signed'(rd_rear_reg);
            out_empty_reg <= (count_reg == '0);
            out_full_reg  <= (count_reg == lim);
            out_count_reg <= count_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.rear_value  = out_rear_reg;
    assign rsp.is_empty    = out_empty_reg;
    assign rsp.is_full     = out_full_reg;
    assign rsp.entry_count = out_count_reg;

endmodule

// File: sim/bdq_checker.sv
module bdq_checker #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [bdq_pkg::APB_AW-1:0] paddr,
    input  logic [bdq_pkg::APB_DW-1:0] pwdata,
    bdq_req_if                         req,
    bdq_rsp_if                         rsp,
    output int                         pending,
    output int                         mismatches
);
    import bdq_pkg::*;

    typedef struct {
        logic                     ok;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
        logic [CNT_W-1:0]         entry_count;
    } deque_view_t;

    logic signed [WORD_W-1:0] word_store [DEPTH];
    int                       front_slot;
    int                       held;
    logic [CNT_W-1:0]         capacity;
    deque_view_t              expected_views [$];

    function automatic int capacity_limit();
        int c;
        c = int'(capacity);
        if (c == 0)
            c = 1;
        if (c > DEPTH)
            c = DEPTH;
        return c;
    endfunction

    function automatic deque_view_t apply_request(input logic [ACT_W-1:0] act,
                                                  input logic signed [WORD_W-1:0] word);
        deque_view_t v;
        int          lim;
        lim  = capacity_limit();
        v.ok = 1'b1;
        case (act)
            ACT_PUSH_FRONT:
                if (held >= lim)
                    v.ok = 1'b0;
                else
                begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    word_store[front_slot] = word;
                    held++;
                end
            ACT_PUSH_REAR:
                if (held >= lim)
                    v.ok = 1'b0;
                else
                begin
                    word_store[(front_slot + held) % DEPTH] = word;
                    held++;
                end
            ACT_POP_FRONT:
                if (held == 0)
                    v.ok = 1'b0;
                else
                begin
                    front_slot = (front_slot + 1) % DEPTH;
                    held--;
                end
            ACT_POP_REAR:
                if (held == 0)
                    v.ok = 1'b0;
                else
                    held--;
            default:
                ;
        endcase
        if (held == 0)
        begin
            v.front_value = EMPTY_WORD;
            v.rear_value  = EMPTY_WORD;
        end
        else
        begin
            v.front_value = word_store[front_slot];
            v.rear_value  = word_store[(front_slot + held - 1) % DEPTH];
        end
        v.is_empty    = (held == 0);
        v.is_full     = (held == lim);
        v.entry_count = CNT_W'(held);
        return v;
    endfunction

    function automatic void compare_view(input deque_view_t exp);
        if (rsp.ok !== exp.ok)
        begin
            $display("%0t: ok mismatch: expected %0d, actual %0d", $time, exp.ok, rsp.ok);
            mismatches++;
        end
        if (rsp.front_value !== exp.front_value)
        begin
            $display("%0t: front_value mismatch: expected %0d, actual %0d",
                     $time, exp.front_value, rsp.front_value);
            mismatches++;
        end
        if (rsp.rear_value !== exp.rear_value)
        begin
            $display("%0t: rear_value mismatch: expected %0d, actual %0d",
                     $time, exp.rear_value, rsp.rear_value);
            mismatches++;
        end
        if (rsp.is_empty !== exp.is_empty)
        begin
            $display("%0t: is_empty mismatch: expected %0d, actual %0d",
                     $time, exp.is_empty, rsp.is_empty);
            mismatches++;
        end
        if (rsp.is_full !== exp.is_full)
        begin
            $display("%0t: is_full mismatch: expected %0d, actual %0d",
                     $time, exp.is_full, rsp.is_full);
            mismatches++;
        end
        if (rsp.entry_count !== exp.entry_count)
        begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, exp.entry_count, rsp.entry_count);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_slot = 0;
            held       = 0;
            capacity   = CAP_RESET;
            expected_views.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_CAPACITY)
            begin
                capacity   = pwdata[CNT_W-1:0];
                front_slot = 0;
                held       = 0;
            end
            if (req.valid && req.ready)
                expected_views.push_back(apply_request(req.action, req.value));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $display("%0t: unexpected response transaction: expected none, actual count %0d",
                             $time, rsp.entry_count);
                    mismatches++;
                end
                else
                    compare_view(expected_views.pop_front());
            end
            pending = expected_views.size();
        end
    end

endmodule

// File: sim/tb_top.sv
module tb_top;
    import bdq_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    // action codes outside the defined set; the block treats them as no change
    localparam logic [ACT_W-1:0] ACT_UNDEF_LO  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNDEF_MID = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNDEF_HI  = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                pending;
    int                mismatches;
    int                idle_max;
    int                cycle_count = 0;

    bdq_req_if req_ch();
    bdq_rsp_if rsp_ch();

    bounded_double_ended_queue dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    bdq_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // response side: random stall before each transaction
    initial
    begin : rsp_drain
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, idle_max);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    task automatic send_request(input logic [ACT_W-1:0] act,
                                input logic signed [WORD_W-1:0] word);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= word;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] cap);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= APB_DW'(cap);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_mix(input int n, input int push_pct, input int pop_pct);
        int                       roll;
        logic [ACT_W-1:0]         act;
        logic signed [WORD_W-1:0] word;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
            else if (roll < push_pct + pop_pct)
                act = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
            else
                act = ACT_W'($urandom_range(ACT_NOP, ACT_UNDEF_HI));
            if ($urandom_range(0, 15) == 0)
                word = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            else
                word = $urandom();
            send_request(act, word);
        end
    endtask

    initial
    begin : stimulus
        logic [CNT_W-1:0] phase_caps [8];
        phase_caps = '{11'd1, 11'd3, 11'd0, 11'd5, 11'd2, 11'd17, 11'd1025, 11'd2047};

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_NOP;
        req_ch.value  = '0;
        idle_max      = 13;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque at reset capacity, undefined actions, extreme words
        send_request(ACT_POP_FRONT, 32'sd5);
        send_request(ACT_POP_REAR, -32'sd1);
        send_request(ACT_NOP, 32'sd9);
        send_request(ACT_UNDEF_LO, 32'sd1);
        send_request(ACT_UNDEF_MID, 32'sd2);
        send_request(ACT_UNDEF_HI, 32'sd3);
        send_request(ACT_PUSH_FRONT, 32'sh7fff_ffff);
        send_request(ACT_PUSH_REAR, 32'sh8000_0000);
        send_request(ACT_PUSH_FRONT, -32'sd1);
        send_request(ACT_PUSH_REAR, 32'sd0);
        send_request(ACT_POP_FRONT, 32'sd0);
        send_request(ACT_POP_REAR, 32'sd0);
        send_request(ACT_NOP, 32'sd0);

        // full and refused pushes at capacity 2
        set_capacity(11'd2);
        send_request(ACT_PUSH_REAR, 32'sd100);
        send_request(ACT_PUSH_FRONT, -32'sd200);
        send_request(ACT_PUSH_REAR, 32'sd300);
        send_request(ACT_PUSH_FRONT, 32'sd400);
        send_request(ACT_POP_REAR, 32'sd0);
        send_request(ACT_POP_FRONT, 32'sd0);
        send_request(ACT_POP_FRONT, 32'sd0);

        // zero capacity acts as one
        set_capacity(11'd0);
        send_request(ACT_PUSH_FRONT, 32'sd77);
        send_request(ACT_PUSH_REAR, 32'sd78);
        send_request(ACT_POP_REAR, 32'sd0);
        send_request(ACT_POP_REAR, 32'sd0);

        // capacity above the store depth
        set_capacity(11'd2047);
        send_request(ACT_PUSH_REAR, 32'sh1234_5678);
        send_request(ACT_POP_FRONT, 32'sd0);

        foreach (phase_caps[i])
        begin
            set_capacity(phase_caps[i]);
            idle_max = (i % 3 == 2) ? 0 : 13;
            run_mix($urandom_range(5, 12), 75, 15);
            run_mix($urandom_range(5, 12), 20, 70);
            run_mix($urandom_range(5, 12), 60, 30);
        end

        // fill the whole store, with and without idle stretches
        set_capacity(11'd1024);
        for (int k = 0; k < 7; k++)
        begin
            idle_max = (k % 2 == 0) ? 13 : 0;
            run_mix(140, 97, 1);
        end
        idle_max = 5;
        run_mix(100, 100, 0);
        idle_max = 13;
        run_mix(40, 40, 50);

        drain_results();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
